// ----- hdl/rbec_pkg.sv -----
// ----------------------------------------------------------------------------
// rbec_pkg
// Shared types, constants and small helper functions for the BCD calendar /
// Unix seconds converter.
// ----------------------------------------------------------------------------
package rbec_pkg;

  // Command codes carried on the input tuser
  localparam logic CMD_TO_EPOCH = 1'b0;
  localparam logic CMD_TO_BCD   = 1'b1;

  // Time constants
  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN    = 32'd60;
  localparam logic [31:0] EPOCH_2000      = 32'd946684800;
  // 2100-01-01 minus 2000-01-01, in seconds
  localparam logic [31:0] EPOCH_SPAN      = 32'd3155760000;
  localparam logic [31:0] DAYS_PER_4YEARS = 32'd1461;
  localparam logic [31:0] DAYS_PER_YEAR   = 32'd365;
  localparam logic [15:0] EPOCH_DAYS_2000 = 16'd10957;

  // One input item
  typedef struct packed {
    logic        command;
    logic [31:0] epoch;
    logic [7:0]  sec_bcd;
    logic [7:0]  min_bcd;
    logic [7:0]  hour_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  month_bcd;
    logic [7:0]  year_bcd;
  } rbec_req_t;

  // One result item
  typedef struct packed {
    logic [31:0] epoch;
    logic [7:0]  sec_bcd;
    logic [7:0]  min_bcd;
    logic [5:0]  hour_bcd;
    logic [5:0]  day_bcd;
    logic [4:0]  month_bcd;
    logic [7:0]  year_bcd;
    logic        range_error;
  } rbec_result_t;

  // Both nibbles are decimal digits
  function automatic logic bcd_ok(input logic [7:0] b);
    return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  // Packed BCD (two valid digits) to binary
  function automatic logic [6:0] bcd2bin(input logic [7:0] b);
    return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
  endfunction

  // Binary 0-99 to packed BCD; tens by reciprocal 205/2048
  function automatic logic [7:0] bin2bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // Days in the months before the given month (1-12)
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month (1-12) in a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd2:                         d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                 d = 5'd31;
      default:                      d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/rbec_alu.sv -----
// ----------------------------------------------------------------------------
// rbec_alu
// Shared 32-bit add / subtract unit with a greater-or-equal flag taken from
// the carry out of the subtraction.
// ----------------------------------------------------------------------------
module rbec_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] result,
  output logic        ge
);

  logic [32:0] sum;

  // a + b, or a + ~b + 1 for subtraction
  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + 33'(sub);
  assign result = sum[31:0];
  assign ge     = sum[32];

endmodule

// ----- hdl/rbec_core.sv -----
// ----------------------------------------------------------------------------
// rbec_core
// Sequencer around the shared add/subtract unit. Calendar to seconds runs a
// shift-add multiply per field but seconds; seconds to calendar runs restoring
// division for day / hour / minute, then walks four-year blocks, years, months.
// ----------------------------------------------------------------------------
module rbec_core
  import rbec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  rbec_req_t    req,
  output logic         ready,
  output logic         res_valid,
  input  logic         res_ready,
  output rbec_result_t res
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_DAY,
    ST_E_HOUR,
    ST_E_MIN,
    ST_E_SEC,
    ST_D_OFF,
    ST_D_RNG,
    ST_D_DAY,
    ST_D_HOUR,
    ST_D_MIN,
    ST_D_Y4,
    ST_D_Y1,
    ST_D_MON,
    ST_DONE
  } state_t;

  localparam logic [15:0] DAYS_BASE = EPOCH_DAYS_2000 - 16'd1;

  state_t      state;
  logic [31:0] acc;
  logic [15:0] num;
  logic [3:0]  k;
  logic [6:0]  hour_v;
  logic [6:0]  min_v;
  logic [6:0]  sec_v;
  logic [6:0]  year_v;
  logic [3:0]  month_v;
  logic        cmd;
  logic        err;

  // ALU hookup
  logic [31:0] opnd;
  logic        sub;
  logic [31:0] alu_res;
  logic        alu_ge;

  rbec_alu u_alu (
    .a      (acc),
    .b      (opnd),
    .sub    (sub),
    .result (alu_res),
    .ge     (alu_ge)
  );

  // Calendar input decode
  logic [6:0]  sec_b, min_b, hour_b, day_b, mon_b, yr_b;
  logic        bcd_bad, mon_bad, leap_adj;
  logic [15:0] days_enc;

  always_comb begin
    sec_b    = bcd2bin(req.sec_bcd);
    min_b    = bcd2bin(req.min_bcd);
    hour_b   = bcd2bin(req.hour_bcd);
    day_b    = bcd2bin(req.day_bcd);
    mon_b    = bcd2bin(req.month_bcd);
    yr_b     = bcd2bin(req.year_bcd);
    bcd_bad  = !(bcd_ok(req.sec_bcd) && bcd_ok(req.min_bcd) && bcd_ok(req.hour_bcd) &&
                 bcd_ok(req.day_bcd) && bcd_ok(req.month_bcd) && bcd_ok(req.year_bcd));
    mon_bad  = (mon_b < 7'd1) || (mon_b > 7'd12);
    leap_adj = (mon_b > 7'd2) && (yr_b[1:0] == 2'b00);
    days_enc = 16'(day_b) + 16'(cum_days(mon_b[3:0])) + 16'(leap_adj)
             + 16'(yr_b) * 16'd365 + 16'((8'(yr_b) + 8'd3) >> 2) + DAYS_BASE;
  end

  // Operand select for the shared unit
  logic       leap;
  logic [4:0] mlen;

  always_comb begin
    leap = (year_v[1:0] == 2'b00);
    mlen = month_len(month_v) + 5'((leap && (month_v == 4'd2)) ? 1 : 0);
    opnd = '0;
    sub  = 1'b0;
    unique case (state)
      ST_E_DAY:  opnd = num[k] ? (SECS_PER_DAY << k) : '0;
      ST_E_HOUR: opnd = hour_v[k[2:0]] ? (SECS_PER_HOUR << k[2:0]) : '0;
      ST_E_MIN:  opnd = min_v[k[2:0]] ? (SECS_PER_MIN << k[2:0]) : '0;
      ST_E_SEC:  opnd = 32'(sec_v);
      ST_D_OFF: begin
        opnd = EPOCH_2000;
        sub  = 1'b1;
      end
      ST_D_RNG: begin
        opnd = EPOCH_SPAN;
        sub  = 1'b1;
      end
      ST_D_DAY: begin
        opnd = SECS_PER_DAY << k;
        sub  = 1'b1;
      end
      ST_D_HOUR: begin
        opnd = SECS_PER_HOUR << k[2:0];
        sub  = 1'b1;
      end
      ST_D_MIN: begin
        opnd = SECS_PER_MIN << k[2:0];
        sub  = 1'b1;
      end
      ST_D_Y4: begin
        opnd = DAYS_PER_4YEARS;
        sub  = 1'b1;
      end
      ST_D_Y1: begin
        opnd = DAYS_PER_YEAR + 32'(leap);
        sub  = 1'b1;
      end
      ST_D_MON: begin
        opnd = 32'(mlen);
        sub  = 1'b1;
      end
      default: begin
        opnd = '0;
        sub  = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd <= req.command;
            if (req.command == CMD_TO_EPOCH) begin
              if (bcd_bad || mon_bad) begin
                err   <= 1'b1;
                state <= ST_DONE;
              end else begin
                err    <= 1'b0;
                acc    <= '0;
                num    <= days_enc;
                hour_v <= hour_b;
                min_v  <= min_b;
                sec_v  <= sec_b;
                k      <= 4'd15;
                state  <= ST_E_DAY;
              end
            end else begin
              err   <= 1'b0;
              acc   <= req.epoch;
              state <= ST_D_OFF;
            end
          end
        end
        // shift-add multiply of the day count
        ST_E_DAY: begin
          acc <= alu_res;
          if (k == 4'd0) begin
            k     <= 4'd6;
            state <= ST_E_HOUR;
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_E_HOUR: begin
          acc <= alu_res;
          if (k == 4'd0) begin
            k     <= 4'd6;
            state <= ST_E_MIN;
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_E_MIN: begin
          acc <= alu_res;
          if (k == 4'd0) begin
            state <= ST_E_SEC;
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_E_SEC: begin
          acc   <= alu_res;
          state <= ST_DONE;
        end
        // lower bound and 2000 offset
        ST_D_OFF: begin
          if (!alu_ge) begin
            err   <= 1'b1;
            state <= ST_DONE;
          end else begin
            acc   <= alu_res;
            state <= ST_D_RNG;
          end
        end
        // upper bound, compare only
        ST_D_RNG: begin
          if (alu_ge) begin
            err   <= 1'b1;
            state <= ST_DONE;
          end else begin
            hour_v <= '0;
            min_v  <= '0;
            k      <= 4'd15;
            state  <= ST_D_DAY;
          end
        end
        // restoring division by 86400
        ST_D_DAY: begin
          num[k] <= alu_ge;
          if (alu_ge) begin
            acc <= alu_res;
          end
          if (k == 4'd0) begin
            k     <= 4'd4;
            state <= ST_D_HOUR;
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_D_HOUR: begin
          hour_v[k[2:0]] <= alu_ge;
          if (alu_ge) begin
            acc <= alu_res;
          end
          if (k == 4'd0) begin
            k     <= 4'd5;
            state <= ST_D_MIN;
          end else begin
            k <= k - 4'd1;
          end
        end
        ST_D_MIN: begin
          min_v[k[2:0]] <= alu_ge;
          if (k == 4'd0) begin
            // remainder is the seconds; switch acc over to the day count
            sec_v  <= alu_ge ? alu_res[6:0] : acc[6:0];
            acc    <= {16'd0, num};
            year_v <= '0;
            state  <= ST_D_Y4;
          end else begin
            if (alu_ge) begin
              acc <= alu_res;
            end
            k <= k - 4'd1;
          end
        end
        // four-year blocks, each starting with a leap year
        ST_D_Y4: begin
          if (alu_ge) begin
            acc    <= alu_res;
            year_v <= year_v + 7'd4;
          end else begin
            state <= ST_D_Y1;
          end
        end
        ST_D_Y1: begin
          if (alu_ge) begin
            acc    <= alu_res;
            year_v <= year_v + 7'd1;
          end else begin
            month_v <= 4'd1;
            state   <= ST_D_MON;
          end
        end
        ST_D_MON: begin
          if (month_v == 4'd12) begin
            state <= ST_DONE;
          end else if (alu_ge) begin
            acc     <= alu_res;
            month_v <= month_v + 4'd1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result assembly
  always_comb begin
    res = '0;
    if (err) begin
      res.range_error = 1'b1;
    end else if (cmd == CMD_TO_EPOCH) begin
      res.epoch = acc;
    end else begin
      res.sec_bcd   = bin2bcd(sec_v);
      res.min_bcd   = bin2bcd(min_v);
      res.hour_bcd  = 6'(bin2bcd(hour_v));
      res.day_bcd   = 6'(bin2bcd(7'(acc[4:0]) + 7'd1));
      res.month_bcd = 5'(bin2bcd(7'(month_v)));
      res.year_bcd  = bin2bcd(year_v);
    end
  end

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

// ----- hdl/rtc_bcd_epoch_converter_top.sv -----
// ----------------------------------------------------------------------------
// rtc_bcd_epoch_converter_top
// BCD calendar (2000-2099) to Unix seconds and back, one shared adder.
// ----------------------------------------------------------------------------
// Calendar to seconds runs the day, hour and minute multiplies, then adds the
//   seconds; seconds to calendar takes longer for later years and months, and
//   rejected input returns once a check fails. One item at a time: the next
//   is taken after the result enters the output register; the shared unit
//   works one step per cycle. Synchronous reset clears control only.
module rtc_bcd_epoch_converter_top
  import rbec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] epoch_in, [39:32] sec_bcd_in, [47:40] min_bcd_in,
  // [55:48] hour_bcd_in, [63:56] day_bcd_in, [71:64] month_bcd_in,
  // [79:72] year_bcd_in
  input  logic [79:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] epoch_out, [39:32] sec_bcd_out, [47:40] min_bcd_out,
  // [53:48] hour_bcd_out, [59:54] day_bcd_out, [64:60] month_bcd_out,
  // [72:65] year_bcd_out, [79:73] zero
  output logic [79:0] m_axis_tdata,
  // [0] range_error
  output logic        m_axis_tuser
);

  rbec_req_t    req;
  rbec_result_t res;
  logic         core_ready;
  logic         res_valid;
  logic         res_ready;

  // Unpack the input transfer
  always_comb begin
    req.command   = s_axis_tuser;
    req.epoch     = s_axis_tdata[31:0];
    req.sec_bcd   = s_axis_tdata[39:32];
    req.min_bcd   = s_axis_tdata[47:40];
    req.hour_bcd  = s_axis_tdata[55:48];
    req.day_bcd   = s_axis_tdata[63:56];
    req.month_bcd = s_axis_tdata[71:64];
    req.year_bcd  = s_axis_tdata[79:72];
  end

  assign s_axis_tready = core_ready;

  rbec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && core_ready),
    .req       (req),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {7'd0, res.year_bcd, res.month_bcd, res.day_bcd,
                          res.hour_bcd, res.min_bcd, res.sec_bcd, res.epoch};
        m_axis_tuser  <= res.range_error;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/rbec_checker.sv -----
// ----------------------------------------------------------------------------
// rbec_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rbec_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A waiting input transfer holds its fields
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input changed while waiting");

  // One item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // A rejected item carries all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 80'd0)
    else $error("range error with nonzero fields");

  // No result out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind rtc_bcd_epoch_converter_top rbec_checker u_rbec_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/rtc_bcd_epoch_converter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_bcd_epoch_converter_top_test
// Self-checking bench for the BCD calendar / Unix seconds converter. A short
// table of directed transfers (range limits, bad digits, bad months, leap
// days) runs first, then about a thousand random conversions. Every result
// is checked against the bench calendar model or a typed directed result.
// Both stream sides stall at random, and once the output is held off long
// enough to back the input up.
// ----------------------------------------------------------------------------
module rtc_bcd_epoch_converter_top_test;
  import rbec_pkg::*;

  localparam int          RANDOM_ITEMS = 1000;
  localparam int          QUIET_FROM   = 850;     // no idling after this item
  localparam int          HOLD_CYCLES  = 300;     // long output hold-off
  localparam int          HOLD_AFTER   = 150;     // results before the hold-off
  localparam int          DRAIN_CYCLES = 100;     // above the longest latency
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [31:0] SECS_2100    = 32'd4102444800;
  localparam int          MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Rejected conversions return nothing but the error flag
  localparam rbec_result_t REJECT    = '{range_error: 1'b1, default: '0};
  localparam rbec_result_t NOT_TYPED = '0;

  typedef struct packed {
    rbec_req_t    req;
    logic         typed;   // use the result below instead of the model
    rbec_result_t want;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  rbec_result_t pending_results [$];
  int           mismatch_count  = 0;
  int           results_checked = 0;
  int           rejected_count  = 0;
  int           to_epoch_count  = 0;
  int           to_cal_count    = 0;
  int           cycle_count     = 0;
  bit           held_off        = 0;
  bit           quiet_tail      = 0;

  // Directed transfers: limits, every rejection path, leap days, odd fields
  directed_row_t directed_rows [$] = '{
    // 2000-01-01 00:00:00 and 2099-12-31 23:59:59
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1,
      '{epoch: 32'd946684800, default: '0}},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}, 1'b1,
      '{epoch: 32'd4102444799, default: '0}},
    // a non-decimal nibble in each field in turn
    '{'{CMD_TO_EPOCH, 32'h0, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h3F, 8'h01, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h1A, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hF0}, 1'b1, REJECT},
    // months outside 1-12
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00}, 1'b1, REJECT},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h99, 8'h00}, 1'b1, REJECT},
    // out-of-calendar day and time, used as plain numbers
    '{'{CMD_TO_EPOCH, 32'hFFFFFFFF, 8'h99, 8'h99, 8'h99, 8'h00, 8'h12, 8'h99}, 1'b0,
      NOT_TYPED},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h99, 8'h02, 8'h00}, 1'b0, NOT_TYPED},
    // leap days
    '{'{CMD_TO_EPOCH, 32'h0, 8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h00}, 1'b0, NOT_TYPED},
    '{'{CMD_TO_EPOCH, 32'h0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24}, 1'b0, NOT_TYPED},
    // seconds outside 2000-2099, and both ends of the span
    '{'{CMD_TO_BCD, 32'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, REJECT},
    '{'{CMD_TO_BCD, 32'd946684799, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      REJECT},
    '{'{CMD_TO_BCD, 32'd946684800, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{day_bcd: 6'h01, month_bcd: 5'h01, default: '0}},
    '{'{CMD_TO_BCD, 32'd4102444799, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{sec_bcd: 8'h59, min_bcd: 8'h59, hour_bcd: 6'h23, day_bcd: 6'h31,
        month_bcd: 5'h12, year_bcd: 8'h99, default: '0}},
    '{'{CMD_TO_BCD, 32'd4102444800, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      REJECT},
    '{'{CMD_TO_BCD, 32'hFFFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, REJECT},
    // leap days and a late year on the way back
    '{'{CMD_TO_BCD, 32'd951782400, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0,
      NOT_TYPED},
    '{'{CMD_TO_BCD, 32'd951868800, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0,
      NOT_TYPED},
    '{'{CMD_TO_BCD, 32'd1709164800, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0,
      NOT_TYPED},
    '{'{CMD_TO_BCD, 32'd4070908799, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0,
      NOT_TYPED}
  };

  rtc_bcd_epoch_converter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Binary 0-99 to two BCD digits
  function automatic logic [7:0] to_bcd8(input int unsigned v);
    logic [3:0] tens;
    logic [3:0] ones;
    tens = 4'(v / 10);
    ones = 4'(v % 10);
    return {tens, ones};
  endfunction

  // Calendar conversion in both directions, one result per request
  function automatic rbec_result_t convert_calendar(input rbec_req_t req);
    rbec_result_t      res;
    logic [7:0]        digits [6];
    logic [7:0]        b;
    int unsigned       sec, min, hour, day, month, year, days, t, mlen, leap;
    longint unsigned   total;
    res = '0;
    if (req.command == CMD_TO_EPOCH) begin
      digits = '{req.sec_bcd, req.min_bcd, req.hour_bcd, req.day_bcd, req.month_bcd,
                 req.year_bcd};
      foreach (digits[k]) begin
        if (digits[k][7:4] > 4'd9 || digits[k][3:0] > 4'd9) begin
          res.range_error = 1'b1;
          return res;
        end
      end
      sec   = digits[0][7:4] * 10 + digits[0][3:0];
      min   = digits[1][7:4] * 10 + digits[1][3:0];
      hour  = digits[2][7:4] * 10 + digits[2][3:0];
      day   = digits[3][7:4] * 10 + digits[3][3:0];
      month = digits[4][7:4] * 10 + digits[4][3:0];
      year  = digits[5][7:4] * 10 + digits[5][3:0];
      if (month < 1 || month > 12) begin
        res.range_error = 1'b1;
        return res;
      end
      // day is 1-based; the minus one comes after the 2000 offset
      days = day;
      for (int m = 1; m < month; m++) days += MONTH_DAYS[m - 1];
      if (month > 2 && year % 4 == 0) days++;
      days += 365 * year + (year + 3) / 4 + 10957 - 1;
      total = longint'(days) * 86400 + hour * 3600 + min * 60 + sec;
      res.epoch = total[31:0];
    end else begin
      if (req.epoch < EPOCH_2000 || req.epoch >= SECS_2100) begin
        res.range_error = 1'b1;
        return res;
      end
      t    = req.epoch - EPOCH_2000;
      sec  = t % 60;
      t    = t / 60;
      min  = t % 60;
      t    = t / 60;
      hour = t % 24;
      days = t / 24;
      // walk whole years, then whole months
      for (year = 0; year < 99; year++) begin
        leap = (year % 4 == 0) ? 1 : 0;
        if (days < 365 + leap) break;
        days -= 365 + leap;
      end
      leap = (year % 4 == 0) ? 1 : 0;
      for (month = 1; month < 12; month++) begin
        mlen = MONTH_DAYS[month - 1];
        if (leap != 0 && month == 2) mlen++;
        if (days < mlen) break;
        days -= mlen;
      end
      days++;
      res.sec_bcd   = to_bcd8(sec);
      res.min_bcd   = to_bcd8(min);
      b             = to_bcd8(hour);
      res.hour_bcd  = b[5:0];
      b             = to_bcd8(days);
      res.day_bcd   = b[5:0];
      b             = to_bcd8(month);
      res.month_bcd = b[4:0];
      res.year_bcd  = to_bcd8(year);
    end
    return res;
  endfunction

  // Decimal calendar fields (day 1-31 in any month) with a random unused epoch
  function automatic rbec_req_t random_calendar();
    rbec_req_t req;
    req.command   = CMD_TO_EPOCH;
    req.epoch     = $urandom();
    req.sec_bcd   = to_bcd8($urandom_range(0, 59));
    req.min_bcd   = to_bcd8($urandom_range(0, 59));
    req.hour_bcd  = to_bcd8($urandom_range(0, 23));
    req.day_bcd   = to_bcd8($urandom_range(1, 31));
    req.month_bcd = to_bcd8($urandom_range(1, 12));
    req.year_bcd  = to_bcd8($urandom_range(0, 99));
    return req;
  endfunction

  // Offer one request and queue its expected result once it transfers
  task automatic offer_transfer(input rbec_req_t req, input logic typed,
                                input rbec_result_t fixed);
    rbec_result_t want;
    want = typed ? fixed : convert_calendar(req);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.command;
    s_axis_tdata  <= {req.year_bcd, req.month_bcd, req.day_bcd, req.hour_bcd,
                      req.min_bcd, req.sec_bcd, req.epoch};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(want);
    if (req.command == CMD_TO_EPOCH) to_epoch_count++;
    else to_cal_count++;
  endtask

  // Random gap on the input side between transfers
  task automatic input_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      repeat (n) @(negedge clk) s_axis_tvalid <= 1'b0;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    forever @(posedge clk) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("[rtc_bcd_epoch_converter_top] ERROR");
        $finish;
      end
    end
  end

  // Output side: random stalls, one long hold-off, none at the tail
  initial begin
    int n;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held_off && results_checked >= HOLD_AFTER) begin
        held_off = 1;
        repeat (HOLD_CYCLES) @(negedge clk) m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        repeat (n) @(negedge clk) m_axis_tready <= 1'b0;
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) @(negedge clk) m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rbec_result_t got;
    rbec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.epoch       = m_axis_tdata[31:0];
      got.sec_bcd     = m_axis_tdata[39:32];
      got.min_bcd     = m_axis_tdata[47:40];
      got.hour_bcd    = m_axis_tdata[53:48];
      got.day_bcd     = m_axis_tdata[59:54];
      got.month_bcd   = m_axis_tdata[64:60];
      got.year_bcd    = m_axis_tdata[72:65];
      got.range_error = m_axis_tuser;
      results_checked++;
      if (got.range_error) rejected_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with no conversion pending: tdata %h tuser %b", $realtime,
                   m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (got.epoch != want.epoch || got.sec_bcd != want.sec_bcd ||
            got.min_bcd != want.min_bcd || got.hour_bcd != want.hour_bcd ||
            got.day_bcd != want.day_bcd || got.month_bcd != want.month_bcd ||
            got.year_bcd != want.year_bcd || got.range_error != want.range_error ||
            m_axis_tdata[79:73] != 7'd0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch on result %0d (pad %h)", $realtime, results_checked,
                     m_axis_tdata[79:73]);
            $display("  expected epoch %h s %h m %h h %h d %h mo %h y %h err %b",
                     want.epoch, want.sec_bcd, want.min_bcd, want.hour_bcd, want.day_bcd,
                     want.month_bcd, want.year_bcd, want.range_error);
            $display("  actual   epoch %h s %h m %h h %h d %h mo %h y %h err %b",
                     got.epoch, got.sec_bcd, got.min_bcd, got.hour_bcd, got.day_bcd,
                     got.month_bcd, got.year_bcd, got.range_error);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    rbec_req_t    req;
    rbec_result_t cal;
    int unsigned  kind;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TO_EPOCH;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_transfer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      input_gap();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) quiet_tail = 1;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          // seconds anywhere in the supported span
          req         = random_calendar();
          req.command = CMD_TO_BCD;
          req.epoch   = $urandom_range(32'd946684800, 32'd4102444799);
        end
        3: begin
          // a couple of seconds around midnight on the first of a month
          req          = random_calendar();
          req.day_bcd  = 8'h01;
          req.hour_bcd = 8'h00;
          req.min_bcd  = 8'h00;
          req.sec_bcd  = 8'h00;
          cal          = convert_calendar(req);
          req.epoch    = cal.epoch - 32'd2 + 32'($urandom_range(0, 3));
          req.command  = CMD_TO_BCD;
          req.sec_bcd  = 8'($urandom_range(0, 255));
        end
        4, 5, 6: req = random_calendar();
        7: begin
          // decimal digits, but day and time beyond the calendar
          req           = random_calendar();
          req.sec_bcd   = to_bcd8($urandom_range(0, 99));
          req.min_bcd   = to_bcd8($urandom_range(0, 99));
          req.hour_bcd  = to_bcd8($urandom_range(0, 99));
          req.day_bcd   = to_bcd8($urandom_range(0, 99));
          if ($urandom_range(0, 7) == 0) req.month_bcd = to_bcd8($urandom_range(0, 99));
        end
        8: begin
          // raw bytes, mostly rejected
          req           = random_calendar();
          req.sec_bcd   = 8'($urandom_range(0, 255));
          req.min_bcd   = 8'($urandom_range(0, 255));
          req.hour_bcd  = 8'($urandom_range(0, 255));
          req.day_bcd   = 8'($urandom_range(0, 255));
          req.month_bcd = 8'($urandom_range(0, 255));
          req.year_bcd  = 8'($urandom_range(0, 255));
        end
        default: begin
          req         = random_calendar();
          req.command = CMD_TO_BCD;
          req.epoch   = $urandom();
        end
      endcase
      offer_transfer(req, 1'b0, NOT_TYPED);
      input_gap();
    end
    @(negedge clk) s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d calendars to seconds and %0d seconds to calendars;",
             to_epoch_count, to_cal_count);
    $display("%0d results checked, %0d rejected, %0d mismatches, output held %0d cycles once.",
             results_checked, rejected_count, mismatch_count, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("[rtc_bcd_epoch_converter_top] OK");
    end else begin
      $display("[rtc_bcd_epoch_converter_top] ERROR");
    end
    $finish;
  end

endmodule
